// ===== hw/rtl/sepq_pkg.sv =====
// shared types and constants for the sorted event priority queue
package sepq_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int TIME_W = 32;
    localparam int KIND_W = 8;
    localparam int OCC_W  = 5;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POLL = 1'b1
    } t_op;

    typedef struct packed {
        logic [KIND_W-1:0] ev_kind;
        logic [TIME_W-1:0] ev_time;
    } t_entry;

    // request from the sequencer to the entry store
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_entry            wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        t_status           status;
        logic [TIME_W-1:0] rtime;
        logic [KIND_W-1:0] rkind;
        logic [OCC_W-1:0]  occ;
    } t_result;

endpackage

// ===== hw/rtl/sepq_store.sv =====
// entry memory: one write port, one registered read port
module sepq_store
    import sepq_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_entry   o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/sepq_ctrl.sv =====
// sequencer: one compare and one entry move per step over the entry store
module sepq_ctrl
    import sepq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_op               i_op,
    input  logic [TIME_W-1:0] i_time,
    input  logic [KIND_W-1:0] i_kind,
    output t_mem_req          o_mem,
    input  t_entry            i_rdata,
    input  logic              i_out_free,
    output logic              o_done,
    output t_result           o_result
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_PUSH_CMP = 6'b000010,
        S_PUSH_INS = 6'b000100,
        S_POP_HEAD = 6'b001000,
        S_POP_MOVE = 6'b010000,
        S_DONE     = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_idx, n_idx;
    t_entry            r_new, n_new;
    t_status           r_status, n_status;
    logic [TIME_W-1:0] r_rtime, n_rtime;
    logic [KIND_W-1:0] r_rkind, n_rkind;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_new    = r_new;
        n_status = r_status;
        n_rtime  = r_rtime;
        n_rkind  = r_rkind;
        o_mem.we    = 1'b0;
        o_mem.waddr = '0;
        o_mem.wdata = r_new;
        o_mem.raddr = '0;
        o_done      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_new.ev_time = i_time;
                    n_new.ev_kind = i_kind;
                    n_status      = ST_OK;
                    n_rtime       = '0;
                    n_rkind       = '0;
                    if (i_op == OP_PUSH) begin
                        if (r_count == CNT_W'(DEPTH)) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else if (r_count == '0) begin
                            o_mem.we            = 1'b1;
                            o_mem.waddr         = '0;
                            o_mem.wdata.ev_time = i_time;
                            o_mem.wdata.ev_kind = i_kind;
                            n_count             = r_count + CNT_W'(1);
                            n_state             = S_DONE;
                        end else begin
                            // walk down from the tail, starting with the last entry
                            o_mem.raddr = ADDR_W'(r_count - CNT_W'(1));
                            n_idx       = r_count;
                            n_state     = S_PUSH_CMP;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            o_mem.raddr = '0;
                            n_idx       = CNT_W'(1);
                            n_state     = S_POP_HEAD;
                        end
                    end
                end
            end
            S_PUSH_CMP: begin
                // i_rdata is entry r_idx-1
                o_mem.we    = 1'b1;
                o_mem.waddr = r_idx[ADDR_W-1:0];
                if (i_rdata.ev_time >= r_new.ev_time) begin
                    o_mem.wdata = i_rdata;
                    n_idx       = r_idx - CNT_W'(1);
                    if (r_idx == CNT_W'(1)) begin
                        n_state = S_PUSH_INS;
                    end else begin
                        o_mem.raddr = ADDR_W'(r_idx - CNT_W'(2));
                    end
                end else begin
                    o_mem.wdata = r_new;
                    n_count     = r_count + CNT_W'(1);
                    n_state     = S_DONE;
                end
            end
            S_PUSH_INS: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_idx[ADDR_W-1:0];
                o_mem.wdata = r_new;
                n_count     = r_count + CNT_W'(1);
                n_state     = S_DONE;
            end
            S_POP_HEAD: begin
                n_rtime = i_rdata.ev_time;
                n_rkind = i_rdata.ev_kind;
                if (r_idx >= r_count) begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_DONE;
                end else begin
                    o_mem.raddr = r_idx[ADDR_W-1:0];
                    n_state     = S_POP_MOVE;
                end
            end
            S_POP_MOVE: begin
                // i_rdata is entry r_idx, moves one slot toward the front
                o_mem.we    = 1'b1;
                o_mem.waddr = ADDR_W'(r_idx - CNT_W'(1));
                o_mem.wdata = i_rdata;
                n_idx       = r_idx + CNT_W'(1);
                if (n_idx < r_count) begin
                    o_mem.raddr = n_idx[ADDR_W-1:0];
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_done = 1'b1;
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_idx    <= n_idx;
        r_new    <= n_new;
        r_status <= n_status;
        r_rtime  <= n_rtime;
        r_rkind  <= n_rkind;
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_result.status = r_status;
    assign o_result.rtime  = r_rtime;
    assign o_result.rkind  = r_rkind;
    assign o_result.occ    = OCC_W'(32'(r_count));

endmodule

// ===== hw/rtl/sorted_event_priority_queue.sv =====
// top level: sorted event queue, stream ports and result register
// Bounded priority queue of events kept in timestamp order, smallest first, in a
// 16-entry memory (DEPTH in sepq_pkg). Each input transfer is a push (tuser 0) or
// a poll (tuser 1) and gives exactly one output transfer with a status: ok, empty
// on a poll of an empty queue, or full on a rejected push. A push goes in ahead of
// the first entry whose time is greater or equal, so among equal times the newest
// leaves first. The block takes one item at a time; s_axis_tready is low until the
// result has moved into the output register. A push moves each stored entry with a
// later or equal time one slot back, starting from the tail, and writes the new
// entry into the gap; on an empty queue it is written straight to slot 0, and on a
// full queue it is rejected without touching the memory. A poll reads the head and
// moves each of the other entries one slot toward the front. s_axis_tready comes
// back as the result appears in the output register, and stays low while the
// receiver leaves the output register full. The pace is set by the entry memory,
// which moves one entry per cycle through its single read and single write port,
// with the one timestamp comparator deciding at each step where the new entry stops.
// No clearing pass is needed after reset: only entries below the count are read.
module sorted_event_priority_queue
    import sepq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // event_time[31:0], event_kind[39:32]
    input  logic [0:0]  s_axis_tuser,   // operation[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // out_time[31:0], out_kind[39:32], occupancy[44:40]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    t_mem_req w_mem;
    t_entry   w_rdata;
    t_result  w_result;
    logic     w_done;
    logic     w_out_free;

    logic        r_m_valid;
    logic [47:0] r_m_data;
    logic [1:0]  r_m_user;

    // output register is free when empty or being drained this cycle
    assign w_out_free = !r_m_valid || m_axis_tready;

    sepq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_op       (t_op'(s_axis_tuser[0])),
        .i_time     (s_axis_tdata[31:0]),
        .i_kind     (s_axis_tdata[39:32]),
        .o_mem      (w_mem),
        .i_rdata    (w_rdata),
        .i_out_free (w_out_free),
        .o_done     (w_done),
        .o_result   (w_result)
    );

    sepq_store u_store (
        .i_clk   (i_clk),
        .i_req   (w_mem),
        .o_rdata (w_rdata)
    );

    // result register, loaded when the sequencer finishes and the slot is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_done && w_out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
        if (w_done && w_out_free) begin
            r_m_data <= {3'b000, w_result.occ, w_result.rkind, w_result.rtime};
            r_m_user <= w_result.status;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    // the block is busy right after taking an item
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after an accepted transfer");

    // an empty-status result carries no event and an empty queue
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_EMPTY) |->
            (m_axis_tdata[44:0] == 45'd0))
        else $error("empty result with nonzero payload");

    // a rejected push reports a full queue
    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_FULL) |->
            (m_axis_tdata[44:40] == OCC_W'(DEPTH)) && (m_axis_tdata[39:0] == 40'd0))
        else $error("full result with wrong occupancy or payload");

    // a new result only appears when the sequencer finishes
    a_load_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_done))
        else $error("result register loaded without a finished item");

endmodule

// ===== verif/tb_top.sv =====
// testbench for the sorted event priority queue: stimulus, prediction and result checks
module tb_top
    import sepq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // clock, reset and stream signals; those the bench drives start at a known value from time zero
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // event_time[31:0], event_kind[39:32]
    logic [0:0]  s_axis_tuser = '0;   // operation[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // out_time[31:0], out_kind[39:32], occupancy[44:40]
    logic [1:0]  m_axis_tuser;        // status[1:0]

    sorted_event_priority_queue dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predicted contents of the queue, slot 0 is the front
    t_entry  model_entries[DEPTH];
    int      model_count = 0;

    // results predicted at input transfers, oldest first
    t_result awaited_results[$];
    int      mismatch_count = 0;

    // random idling switches and the long receiver hold-off
    bit      sender_idling = 1'b1;
    bit      sink_idling = 1'b1;
    int      sink_hold_cycles = 0;

    // queue behavior for one push or poll; updates the predicted contents
    function automatic t_result predict_queue_op(t_op op, logic [TIME_W-1:0] ts,
                                                 logic [KIND_W-1:0] kind);
        t_result r;
        int      pos;
        r.status = ST_OK;
        r.rtime  = '0;
        r.rkind  = '0;
        if (op == OP_PUSH) begin
            if (model_count >= DEPTH) begin
                // rejected, queue untouched
                r.status = ST_FULL;
            end else begin
                // goes ahead of the first entry with a time >= its own,
                // so the newest of equal times leaves first
                pos = 0;
                while (pos < model_count && model_entries[pos].ev_time < ts)
                    pos++;
                for (int i = model_count; i > pos; i--)
                    model_entries[i] = model_entries[i-1];
                model_entries[pos].ev_time = ts;
                model_entries[pos].ev_kind = kind;
                model_count++;
            end
        end else begin
            if (model_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.rtime = model_entries[0].ev_time;
                r.rkind = model_entries[0].ev_kind;
                for (int i = 1; i < model_count; i++)
                    model_entries[i-1] = model_entries[i];
                model_count--;
            end
        end
        r.occ = OCC_W'(model_count);
        return r;
    endfunction

    // offer one item and hold it until the transfer; valid stays high afterwards
    // so back-to-back items need no extra assignment in the same step
    task automatic send_event(t_op op, logic [TIME_W-1:0] ts, logic [KIND_W-1:0] kind);
        if (sender_idling && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {kind, ts};
        s_axis_tuser  <= op;
        do
            @(posedge i_clk);
        while (!(s_axis_tvalid && s_axis_tready));
        awaited_results.push_back(predict_queue_op(op, ts, kind));
    endtask

    // stop offering and wait for every predicted result to come out
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge i_clk);
    endtask

    // timestamps weighted toward the extremes and toward ties
    function automatic logic [TIME_W-1:0] random_event_time();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return TIME_W'($urandom_range(0, 7));
            3:       return {16'($urandom_range(0, 3)), 16'h0000};
            4:       return '1 - TIME_W'($urandom_range(0, 3));
            default: return $urandom();
        endcase
    endfunction

    function automatic t_op random_op(int push_pct);
        return ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POLL;
    endfunction

    // extremes, ties, empty and full queue
    task automatic test_directed();
        send_event(OP_POLL, '0, '0);             // poll of an empty queue
        send_event(OP_PUSH, '1, '1);
        send_event(OP_PUSH, '0, '0);
        send_event(OP_PUSH, 32'd5, 8'd1);
        send_event(OP_PUSH, 32'd5, 8'd2);        // tie: newer goes in front
        send_event(OP_POLL, '1, '1);             // poll ignores its data fields
        send_event(OP_POLL, '0, '0);
        send_event(OP_PUSH, '1, 8'h5a);          // tie at the largest time
        for (int i = 0; i < 13; i++)
            send_event(OP_PUSH, random_event_time(), 8'($urandom()));
        send_event(OP_PUSH, 32'd7, 8'ha5);       // push into a full queue
        send_event(OP_POLL, '0, '0);
        send_event(OP_POLL, '0, '0);
        wait_results_drained();
    endtask

    // phases with a random push bias so the queue swings between empty and full
    task automatic test_random_mix(int phases);
        int push_pct;
        for (int p = 0; p < phases; p++) begin
            case ($urandom_range(0, 3))
                0:       push_pct = 85;
                1:       push_pct = 20;
                default: push_pct = 50;
            endcase
            repeat (50)
                send_event(random_op(push_pct), random_event_time(), 8'($urandom()));
        end
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_sink_hold();
        sink_hold_cycles = 120;
        repeat (30)
            send_event(random_op(60), random_event_time(), 8'($urandom()));
    endtask

    // sender pauses until the block has delivered everything
    task automatic test_sender_pause();
        repeat (25)
            send_event(random_op(70), random_event_time(), 8'($urandom()));
        wait_results_drained();
        repeat (25)
            send_event(random_op(40), random_event_time(), 8'($urandom()));
    endtask

    // full throughput on both sides
    task automatic test_no_idling();
        sender_idling = 1'b0;
        sink_idling   = 1'b0;
        repeat (4)
            repeat (50)
                send_event(random_op($urandom_range(15, 85)), random_event_time(),
                           8'($urandom()));
    endtask

    // receiver ready: long hold-off first, then random short stalls
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                sink_hold_cycles--;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if (sink_idling && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                stall_left = $urandom_range(1, 3) - 1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // result check against the oldest prediction
    initial begin
        t_result exp_res;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                if (awaited_results.size() == 0) begin
                    $error("result transfer with no prediction pending");
                    mismatch_count++;
                end else begin
                    exp_res = awaited_results.pop_front();
                    if (m_axis_tuser !== exp_res.status) begin
                        $error("status: expected %0d, actual %0d", exp_res.status,
                               m_axis_tuser);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[31:0] !== exp_res.rtime) begin
                        $error("out_time: expected %h, actual %h", exp_res.rtime,
                               m_axis_tdata[31:0]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[39:32] !== exp_res.rkind) begin
                        $error("out_kind: expected %h, actual %h", exp_res.rkind,
                               m_axis_tdata[39:32]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[44:40] !== exp_res.occ) begin
                        $error("occupancy: expected %0d, actual %0d", exp_res.occ,
                               m_axis_tdata[44:40]);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // test sequence
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_mix(14);
        test_sink_hold();
        test_sender_pause();
        test_no_idling();
        wait_results_drained();
        // leave room for a stray result
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("sorted_event_priority_queue regression: pass");
        end else begin
            $display("sorted_event_priority_queue regression: fail");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("sorted_event_priority_queue regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/sepq_pkg.sv
hw/rtl/sepq_store.sv
hw/rtl/sepq_ctrl.sv
hw/rtl/sorted_event_priority_queue.sv
verif/tb_top.sv
